[rtl/crd_pkg.sv]
package crd_pkg;

  // Payload store sizing, two banks so one frame drains while the next fills
  localparam int MAX_PAYLOAD = 10;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int STORE_DEPTH = 2 * MAX_PAYLOAD;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Job queue between parser and result sequencer (depth is a power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Frame layout
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [4:0] POS_HDR    = 5'd0;
  localparam logic [4:0] POS_STATUS = 5'd3;
  localparam logic [4:0] POS_LEN    = 5'd4;
  localparam logic [4:0] POS_DATA   = 5'd5;
  localparam logic [4:0] POS_MAX    = 5'd31;

  localparam logic [3:0] MAX_PAYLOAD_RST = 4'd1;
  localparam logic [7:0] LIMIT_CAP       = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    RC_OK     = 3'd0,
    RC_SHORT  = 3'd1,
    RC_HEADER = 3'd2,
    RC_LONG   = 3'd3,
    RC_CHECK  = 3'd4
  } rc_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SHOW
  } back_state_e;

  // One classified frame outcome handed to the result sequencer
  typedef struct packed {
    rc_e        code;
    logic [7:0] status;
    logic [3:0] count;
    logic       bank;
  } crd_job_t;

  // Payload store write request from the parser
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } crd_wr_t;

  function automatic logic [STORE_AW-1:0] store_addr(input logic bank,
                                                     input logic [IDX_W-1:0] idx);
    logic [STORE_AW-1:0] base;
    base = bank ? STORE_AW'(MAX_PAYLOAD) : '0;
    return base + STORE_AW'(idx);
  endfunction

endpackage

[rtl/crd_if.sv]
// Input byte/event channel
interface crd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// Result channel
interface crd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_code;
  logic [7:0] status_byte;
  logic [3:0] data_count;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       last;

  modport source (output valid, output result_code, output status_byte,
                  output data_count, output data_byte, output data_valid,
                  output last, input ready);
  modport sink   (input valid, input result_code, input status_byte,
                  input data_count, input data_byte, input data_valid,
                  input last, output ready);
endinterface

[rtl/crd_front.sv]
module crd_front import crd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  crd_in_if.sink     in_i,
  input  logic       q_full_i,
  input  logic       done_i,
  output logic       push_o,
  output crd_job_t   job_o,
  output crd_wr_t    wr_o
);

  logic [3:0] max_payload_q;
  logic [4:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic       hg_q, hg_d;
  logic [7:0] status_q, status_d;
  logic [3:0] len_q, len_d;
  logic       too_big_q, too_big_d;
  logic       reported_q, reported_d;
  logic       bank_q, bank_d;
  logic [1:0] busy_q, busy_d;
  logic       busy_inc;
  logic       accept;
  logic [7:0] lim;
  logic [7:0] b;
  logic [4:0] rel_pos;

  // Stall while both store banks hold undelivered payloads or the queue is full
  assign in_i.ready = !q_full_i && (busy_q < 2'd2);
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;
  assign rel_pos    = pos_q - POS_DATA;

  // Effective length limit saturates at the size of one store bank
  assign lim = ({4'b0, max_payload_q} > LIMIT_CAP) ? LIMIT_CAP : {4'b0, max_payload_q};

  // Parser: one byte or window event per transfer
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    hg_d       = hg_q;
    status_d   = status_q;
    len_d      = len_q;
    too_big_d  = too_big_q;
    reported_d = reported_q;
    bank_d     = bank_q;
    busy_inc   = 1'b0;
    push_o     = 1'b0;
    job_o      = '{code: RC_OK, status: 8'd0, count: 4'd0, bank: bank_q};
    wr_o       = '{en: 1'b0, addr: store_addr(bank_q, rel_pos[IDX_W-1:0]), data: b};

    if (accept) begin
      if (in_i.action) begin
        // window end: short error unless already reported, then restart
        if (!reported_q) begin
          push_o     = 1'b1;
          job_o.code = RC_SHORT;
        end
        pos_d      = '0;
        sum_d      = '0;
        hg_d       = 1'b0;
        status_d   = '0;
        len_d      = '0;
        too_big_d  = 1'b0;
        reported_d = 1'b0;
      end else if (!reported_q) begin
        if (pos_q == POS_HDR)    hg_d = (b == HDR_BYTE);
        if (pos_q == POS_STATUS) status_d = b;
        if (pos_q == POS_LEN) begin
          too_big_d = (b > lim);
          len_d     = b[3:0];
        end

        if (pos_q == POS_DATA && !hg_q) begin
          reported_d = 1'b1;
          push_o     = 1'b1;
          job_o.code = RC_HEADER;
        end else if (pos_q == POS_DATA && too_big_q) begin
          reported_d   = 1'b1;
          push_o       = 1'b1;
          job_o.code   = RC_LONG;
          job_o.status = status_q;
        end else if (pos_q >= POS_DATA && pos_q == POS_DATA + 5'(len_q)) begin
          // checksum byte
          reported_d   = 1'b1;
          push_o       = 1'b1;
          job_o.status = status_q;
          if (sum_q != b) begin
            job_o.code = RC_CHECK;
          end else begin
            job_o.code  = RC_OK;
            job_o.count = len_q;
            if (len_q != 4'd0) begin
              bank_d   = !bank_q;
              busy_inc = 1'b1;
            end
          end
        end else begin
          if (pos_q >= POS_DATA && 32'(rel_pos) < MAX_PAYLOAD) wr_o.en = 1'b1;
          sum_d = sum_q + b;
          if (pos_q != POS_MAX) pos_d = pos_q + 5'd1;
        end
      end
    end

    busy_d = busy_q + {1'b0, busy_inc} - {1'b0, done_i};
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      hg_q       <= 1'b0;
      status_q   <= '0;
      len_q      <= '0;
      too_big_q  <= 1'b0;
      reported_q <= 1'b0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      hg_q       <= hg_d;
      status_q   <= status_d;
      len_q      <= len_d;
      too_big_q  <= too_big_d;
      reported_q <= reported_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

endmodule

[rtl/crd_queue.sv]
module crd_queue import crd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  crd_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output crd_job_t pop_data_o,
  output logic     empty_o
);

  crd_job_t          slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[rtl/crd_back.sv]
module crd_back import crd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  crd_wr_t  wr_i,
  input  logic     q_empty_i,
  input  crd_job_t q_data_i,
  output logic     pop_o,
  output logic     done_o,
  crd_out_if.source out_o
);

  back_state_e       state_q, state_d;
  crd_job_t          job_q, job_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rdata_q;
  logic              single;
  logic              last_data;

  // Error or empty payload gives exactly one result
  assign single    = (job_q.code != RC_OK) || (job_q.count == 4'd0);
  assign last_data = (32'(idx_q) + 32'd1 == 32'(job_q.count));

  // Payload store: written by the parser, read one byte per result
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rdata_q <= mem[store_addr(job_q.bank, idx_q)];
  end

  // Result sequencer
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = q_data_i;
          idx_d = '0;
          if (q_data_i.code != RC_OK || q_data_i.count == 4'd0) state_d = B_SHOW;
          else                                                  state_d = B_FETCH;
        end
      end
      B_FETCH: state_d = B_SHOW;
      B_SHOW: begin
        if (out_o.ready) begin
          if (single || last_data) begin
            state_d = B_IDLE;
            done_o  = !single;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = B_FETCH;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    idx_q <= idx_d;
  end

  // Result payload
  assign out_o.valid       = (state_q == B_SHOW);
  assign out_o.result_code = job_q.code;
  assign out_o.status_byte = job_q.status;
  assign out_o.data_count  = job_q.count;
  assign out_o.data_byte   = single ? 8'd0 : rdata_q;
  assign out_o.data_valid  = !single;
  assign out_o.last        = single || last_data;

endmodule

[rtl/checksummed_response_deframer.sv]
// Channel    Dir  Payload                                         Transfer
// in_i       in   action, rx_byte                                 valid & ready
// out_o      out  result_code, status_byte, data_count,           valid & ready
//                 data_byte, data_valid, last
// cfg        in   cfg_wdata_i (max_payload)                       cfg_we_i
//
// An input byte is parsed in the cycle of its transfer; a frame outcome goes into a
// two-entry job queue. Each result is read from the payload store, then shown, and
// the next byte is fetched only once the shown result is taken by out_o.ready.
// Input stalls while the queue is full or both payload store banks await draining.
// Reset is asynchronous, active low; it clears control state and sets max_payload to 1.
module checksummed_response_deframer import crd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  crd_in_if.sink     in_i,
  crd_out_if.source  out_o
);

  logic     q_push, q_pop, q_full, q_empty, done;
  crd_job_t push_job, pop_job;
  crd_wr_t  wr;

  crd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .done_i      (done),
    .push_o      (q_push),
    .job_o       (push_job),
    .wr_o        (wr)
  );

  crd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  crd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .q_empty_i (q_empty),
    .q_data_i  (pop_job),
    .pop_o     (q_pop),
    .done_o    (done),
    .out_o     (out_o)
  );

  // Parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("job pushed into full queue");

  // Sequencer never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("job popped from empty queue");

  // A result without payload is always the only one of its frame
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data_valid |-> out_o.last)
    else $error("payload-less result not marked last");

  // Bank release only on the final payload transfer
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_o.valid && out_o.ready && out_o.last && out_o.data_valid)
    else $error("store bank released early");

endmodule

[tb/tb_checksummed_response_deframer.sv]
`timescale 1ns / 100ps

module tb_checksummed_response_deframer;
  import crd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 38;
  localparam int NUM_PHASES  = 8;

  // Input channel actions
  localparam logic ACT_BYTE       = 1'b0;
  localparam logic ACT_WINDOW_END = 1'b1;

  // max_payload per random phase: nominal max, zero, saturating, alternating bits
  localparam logic [3:0] PHASE_MAX_PAYLOAD [NUM_PHASES] =
    '{4'd10, 4'd0, 4'd15, 4'd5, 4'd1, 4'd3, 4'd10, 4'd7};

  typedef struct {
    rc_e        code;
    logic [7:0] status;
    logic [3:0] count;
    logic [7:0] data;
    logic       dvalid;
    logic       last;
  } result_t;

  typedef struct {
    logic       act;
    logic [7:0] rx;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;

  crd_in_if  in_ch();
  crd_out_if out_ch();

  checksummed_response_deframer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  int error_count = 0;
  int items_sent = 0;
  int cycle_count;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  // Deframer state as the predictor sees it
  logic [3:0] cfg_max_payload;
  logic [4:0] frame_pos;
  logic [7:0] frame_sum;
  logic       hdr_ok;
  logic [7:0] held_status;
  logic [3:0] pay_len;
  logic       len_over;
  logic       frame_done;
  logic [7:0] pay_store [MAX_PAYLOAD];

  result_t   pending_results [$];
  stim_row_t directed_rows [$];

  function automatic int payload_limit();
    return (int'(cfg_max_payload) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_max_payload);
  endfunction

  function automatic void restart_frame();
    frame_pos   = '0;
    frame_sum   = '0;
    hdr_ok      = 1'b0;
    held_status = '0;
    pay_len     = '0;
    len_over    = 1'b0;
    frame_done  = 1'b0;
  endfunction

  function automatic void push_result(rc_e code, logic [7:0] status, logic [3:0] count,
                                      logic [7:0] data, logic dvalid, logic last);
    result_t r;
    r = '{code, status, count, data, dvalid, last};
    pending_results.push_back(r);
  endfunction

  // Advance the frame parser by one transfer and queue the results it causes
  function automatic void deframe_step(logic act, logic [7:0] b);
    int pos;
    if (act == ACT_WINDOW_END) begin
      if (!frame_done) push_result(RC_SHORT, 8'h00, 4'd0, 8'h00, 1'b0, 1'b1);
      restart_frame();
      return;
    end
    if (frame_done) return;

    pos = int'(frame_pos);
    if (pos == int'(POS_HDR)) begin
      hdr_ok = (b == HDR_BYTE);
    end else if (pos == int'(POS_STATUS)) begin
      held_status = b;
    end else if (pos == int'(POS_LEN)) begin
      len_over = int'(b) > payload_limit();
      pay_len  = b[3:0];
    end

    // Header and length verdicts land on the sixth byte, header first
    if (pos == int'(POS_DATA) && !hdr_ok) begin
      frame_done = 1'b1;
      push_result(RC_HEADER, 8'h00, 4'd0, 8'h00, 1'b0, 1'b1);
      return;
    end
    if (pos == int'(POS_DATA) && len_over) begin
      frame_done = 1'b1;
      push_result(RC_LONG, held_status, 4'd0, 8'h00, 1'b0, 1'b1);
      return;
    end

    // Checksum byte
    if (pos == int'(POS_DATA) + int'(pay_len)) begin
      frame_done = 1'b1;
      if (frame_sum != b) begin
        push_result(RC_CHECK, held_status, 4'd0, 8'h00, 1'b0, 1'b1);
      end else if (pay_len == 4'd0) begin
        push_result(RC_OK, held_status, 4'd0, 8'h00, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < int'(pay_len); i++)
          push_result(RC_OK, held_status, pay_len, pay_store[i], 1'b1,
                      i == int'(pay_len) - 1);
      end
      return;
    end

    if (pos >= int'(POS_DATA) && pos - int'(POS_DATA) < MAX_PAYLOAD)
      pay_store[pos - int'(POS_DATA)] = b;
    frame_sum = frame_sum + b;
    if (frame_pos != POS_MAX) frame_pos = frame_pos + 5'd1;
  endfunction

  // Directed rows; typed rows carry their single result written out by hand
  function automatic void add_row(logic act, logic [7:0] rx, bit typed = 1'b0,
                                  rc_e code = RC_OK, logic [7:0] status = 8'h00);
    stim_row_t row;
    row.act   = act;
    row.rx    = rx;
    row.typed = typed;
    row.res   = '{code, status, 4'd0, 8'h00, 1'b0, 1'b1};
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // One input transfer, with random sender gaps ahead of it
  task automatic send_item(stim_row_t row);
    int base;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= row.act;
    in_ch.rx_byte <= row.rx;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    base = pending_results.size();
    deframe_step(row.act, row.rx);
    if (row.typed) begin
      while (pending_results.size() > base) void'(pending_results.pop_back());
      pending_results.push_back(row.res);
    end
    items_sent++;
  endtask

  // Let the block go idle: all results in, then its pipeline empty
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_max_payload(logic [3:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    cfg_max_payload  = v;
  endtask

  // Random frame: mostly well formed, some bad checksum, too long, bad header,
  // cut short; optional stray bytes, always closed by a window end
  task automatic send_frame();
    logic [7:0] fb [$];
    logic [7:0] cs;
    int kind, lim, ln, dlen, cut;
    stim_row_t row;
    lim  = payload_limit();
    kind = $urandom_range(0, 99);

    fb.push_back(HDR_BYTE);
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    fb.push_back(8'($urandom));
    if (kind >= 70 && kind < 80) ln = $urandom_range(lim + 1, 255);
    else if ($urandom_range(0, 3) == 0) ln = lim;
    else ln = $urandom_range(0, lim);
    fb.push_back(8'(ln));
    dlen = (ln <= lim) ? ln : $urandom_range(0, 3);
    repeat (dlen) fb.push_back(8'($urandom));
    cs = '0;
    foreach (fb[i]) cs += fb[i];
    if (kind >= 60 && kind < 70) cs ^= 8'($urandom_range(1, 255));
    fb.push_back(cs);

    if (kind >= 80 && kind < 88) begin
      fb[0] = 8'($urandom);
      if (fb[0] == HDR_BYTE) fb[0] = ~HDR_BYTE;
    end
    if (kind >= 88) begin
      cut = $urandom_range(0, fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom));

    row.typed = 1'b0;
    row.act   = ACT_BYTE;
    foreach (fb[i]) begin
      row.rx = fb[i];
      send_item(row);
    end
    row.act = ACT_WINDOW_END;
    row.rx  = 8'($urandom);
    send_item(row);
    // back-to-back window end reports a short frame again
    if ($urandom_range(0, 9) == 0) send_item(row);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_checksummed_response_deframer: done, errors");
    $finish;
  end

  // Result side: check each transfer, then draw the next ready
  initial begin
    result_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: code %0d", out_ch.result_code);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_code", 8'(want.code), 8'(out_ch.result_code));
          check_field("status_byte", want.status, out_ch.status_byte);
          check_field("data_count", 8'(want.count), 8'(out_ch.data_count));
          check_field("data_byte", want.data, out_ch.data_byte);
          check_field("data_valid", 8'(want.dvalid), 8'(out_ch.data_valid));
          check_field("last", 8'(want.last), 8'(out_ch.last));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    int phase_end;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_BYTE;
    in_ch.rx_byte = '0;
    cfg_max_payload = MAX_PAYLOAD_RST;
    restart_frame();
    foreach (pay_store[i]) pay_store[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window end straight out of reset
    add_row(ACT_WINDOW_END, 8'hFF, 1'b1, RC_SHORT);
    // Empty payload; a stray byte and the window end after it are ignored
    add_row(ACT_BYTE, 8'h55);
    add_row(ACT_BYTE, 8'h01);
    add_row(ACT_BYTE, 8'h02);
    add_row(ACT_BYTE, 8'hA5);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'hFD, 1'b1, RC_OK, 8'hA5);
    add_row(ACT_BYTE, 8'hFF);
    add_row(ACT_WINDOW_END, 8'h00);
    // Bad header reported ahead of an oversized length
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h11);
    add_row(ACT_BYTE, 8'h22);
    add_row(ACT_BYTE, 8'h33);
    add_row(ACT_BYTE, 8'hFF);
    add_row(ACT_BYTE, 8'h44, 1'b1, RC_HEADER);
    add_row(ACT_WINDOW_END, 8'h00);
    // Length 0x11: low nibble within limit, full byte is not
    add_row(ACT_BYTE, 8'h55);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h7E);
    add_row(ACT_BYTE, 8'h11);
    add_row(ACT_BYTE, 8'h00, 1'b1, RC_LONG, 8'h7E);
    add_row(ACT_WINDOW_END, 8'h00);
    // Window ends after the sixth byte, checksum never came
    add_row(ACT_BYTE, 8'h55);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h00);
    add_row(ACT_BYTE, 8'h01);
    add_row(ACT_BYTE, 8'h10);
    add_row(ACT_WINDOW_END, 8'h00, 1'b1, RC_SHORT);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_and_settle();

    // Random phases: no idling, sender gaps, receiver stalls, light both
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max_payload(PHASE_MAX_PAYLOAD[p]);
      sender_idle_pct = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 6 : 0;
      recv_stall_pct  = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 6 : 0;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_frame();
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("tb_checksummed_response_deframer: done, clean");
    end else begin
      $display("tb_checksummed_response_deframer: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/crd_pkg.sv
rtl/crd_if.sv
rtl/crd_front.sv
rtl/crd_queue.sv
rtl/crd_back.sv
rtl/checksummed_response_deframer.sv
tb/tb_checksummed_response_deframer.sv
